// ===== hw/rtl/oufr_pkg.sv =====
// ----------------------------------------------------------------------------
// oufr_pkg
// Shared constants, coefficient tables and arithmetic helpers of the
// octave-up filter bank.
// ----------------------------------------------------------------------------
`default_nettype none
package oufr_pkg;

	localparam int BANDS_DEF       = 55;
	localparam int SAMPLE_BITS_DEF = 24;
	localparam int TAB_LEN         = 55;
	localparam int COEF_DEPTH      = 64;
	localparam int ST_W            = 40;  // Q28.12 state
	localparam int CW              = 32;  // Q2.30 coefficient
	localparam int VW              = 48;  // multiplier operand
	localparam int GW              = 16;  // gain register
	localparam int REG_IDX_W       = 2;

	localparam logic [REG_IDX_W-1:0] REG_CLEAN  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_OCT_A  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_OCT_B  = 2'd2;
	localparam logic [GW-1:0]        GAIN_RESET = 16'd4096;

	localparam logic [63:0] POW5_18   = 64'd3814697265625;
	localparam logic [63:0] TEN_POW18 = 64'd1000000000000000000;

	localparam logic signed [53:0] ST_MAX_W = 54'sd549755813887;
	localparam logic signed [53:0] ST_MIN_W = -54'sd549755813888;

	typedef logic signed [CW-1:0] coef_t;
	typedef coef_t coef_rom_t [COEF_DEPTH];
	typedef logic [159:0] txt_t;

	// datapath commands, one step each
	typedef struct packed {
		logic start;     // latch sample, clear band sum
		logic band_go;   // issue band state read
		logic hp_mul_s;  // products of high-pass b coefs and band sum
		logic hp_h;      // form high-pass output
		logic hp_mul_h;  // products of high-pass a coefs and output
		logic hp_st;     // update high-pass states
		logic mix_mul;   // gain products
		logic out_load;  // load output register
	} cmd_t;

	// decimal text to Q2.30, rounded to nearest
	function automatic coef_t q30(input txt_t s);
		logic        neg;
		logic        frac;
		logic [7:0]  ch;
		logic [63:0] ip, fr, scale, n, hi, lo, m;
		neg = 1'b0;
		frac = 1'b0;
		ip = '0;
		fr = '0;
		scale = TEN_POW18;
		for (int k = 19; k >= 0; k--) begin
			ch = s[k*8 +: 8];
			if (ch == "-") begin
				neg = 1'b1;
			end else if (ch == ".") begin
				frac = 1'b1;
			end else if (ch >= "0" && ch <= "9") begin
				if (!frac) begin
					ip = ip * 64'd10 + (64'(ch) - 64'd48);
				end else if (scale > 64'd1) begin
					scale = scale / 10;
					fr = fr + (64'(ch) - 64'd48) * scale;
				end
			end
		end
		n = ip * TEN_POW18 + fr;
		hi = n / POW5_18;
		lo = n % POW5_18;
		m = hi * 64'd4096 + (lo * 64'd4096 + POW5_18 / 2) / POW5_18;
		if (neg) m = -m;
		return m[CW-1:0];
	endfunction

	localparam txt_t A1_TXT [TAB_LEN] = '{
	"-1.99945743773269","-1.99935942906841","-1.99924062977670","-1.99909708277235",
	"-1.99892410985062","-1.99871618287911","-1.99846677223317","-1.99816816848975",
	"-1.99781127270592","-1.99738534980214","-1.99687773863020","-1.99627351120883",
	"-1.99555507233332","-1.99470168928216","-1.99368893962368","-1.99248806313769",
	"-1.99106520157565","-1.98938050735340","-1.98738709926732","-1.98502983991592",
	"-1.98224390566903","-1.97895311574385","-1.97506798222950","-1.97048343779300",
	"-1.96507619239353","-1.95870166479969","-1.95119042932896","-1.94234411345253",
	"-1.93193067840176","-1.91967901366415","-1.90527277869813","-1.88834343336828",
	"-1.86846241538006","-1.84513245237305","-1.81777804381746","-1.78573522094381",
	"-1.74824080170997","-1.70442151569457","-1.65328359840612","-1.59370376851867",
	"-1.52442293367053","-1.44404455593239","-1.35104038852965","-1.24376731735276",
	"-1.12050035106663","-0.979488440212929","-0.819041780213102","-0.637661520103793",
	"-0.434225203748800","-0.208243466153559","0.0397951757780011","0.307975350044821",
	"0.592390391796649","0.886463172281052","1.18017689199105"};

	localparam txt_t A2_TXT [TAB_LEN] = '{
	"0.999623840823723","0.999592083812410","0.999557647639999","0.999520306796363",
	"0.999479816929101","0.999435913307174","0.999388309169729","0.999336693954506",
	"0.999280731400842","0.999220057523294","0.999154278453365","0.999082968148916",
	"0.999005665973701","0.998921874153418","0.998831055119909","0.998732628762124",
	"0.998625969611674","0.998510404002805","0.998385207262283","0.998249601004902",
	"0.998102750636437","0.997943763199395","0.997771685739803","0.997585504428058",
	"0.997384144736516","0.997166473064829","0.996931300315725","0.996677388064530",
	"0.996403458142182","0.996108206671829","0.995790323872893","0.995448521284569",
	"0.995081568475183","0.994688341807231","0.994267888432584","0.993819509407934",
	"0.993342866651437","0.992838119401008","0.992306096857390","0.991748514743871",
	"0.991168244482538","0.990569644389679","0.989958962429589","0.989344819163852",
	"0.988738776872602","0.988155995338887","0.987615964937990","0.987143291300058",
	"0.986768479981635","0.986528630464629","0.986467891703625","0.986637451137907",
	"0.987094720833566","0.987901246292733","0.989118701024236"};

	localparam txt_t B0_TXT [TAB_LEN] = '{
	"0.000188079588138645","0.000203958093794915","0.000221176180000397",
	"0.000239846601818621","0.000260091535449550","0.000282043346413158",
	"0.000305845415135634","0.000331653022746955","0.000359634299578796",
	"0.000389971238353096","0.000422860773317513","0.000458515925542157",
	"0.000497167013149809","0.000539062923291039","0.000584472440045357",
	"0.000633685618937812","0.000687015194163202","0.000744797998597725",
	"0.000807396368858447","0.000875199497549016","0.000948624681781347",
	"0.00102811840030234","0.00111415713009846","0.00120724778597086",
	"0.00130792763174217","0.00141676346758574","0.00153434984213762",
	"0.00166130596773492","0.00179827092890887","0.00194589666408543",
	"0.00210483806355368","0.00227573935771526","0.00245921576240832",
	"0.00265582909638453","0.00286605578370814","0.00309024529603291",
	"0.00332856667428175","0.00358094029949610","0.00384695157130517",
	"0.00412574262806443","0.00441587775873096","0.00471517780516052",
	"0.00502051878520553","0.00532759041807397","0.00563061156369926",
	"0.00592200233055667","0.00619201753100491","0.00642835434997096",
	"0.00661576000918263","0.00673568476768567","0.00676605414818766",
	"0.00668127443104657","0.00645263958321689","0.00604937685363332",
	"0.00544064948788215"};

	// bands past the table have all-zero coefficients
	function automatic coef_rom_t build_rom(input txt_t t [TAB_LEN]);
		coef_rom_t r;
		for (int i = 0; i < COEF_DEPTH; i++) begin
			r[i] = (i < TAB_LEN) ? q30(t[i]) : '0;
		end
		return r;
	endfunction

	localparam coef_rom_t ROM_A1 = build_rom(A1_TXT);
	localparam coef_rom_t ROM_A2 = build_rom(A2_TXT);
	localparam coef_rom_t ROM_B0 = build_rom(B0_TXT);

	localparam coef_t HP_B0 = q30("0.99538200");
	localparam coef_t HP_B1 = q30("-1.99076399");
	localparam coef_t HP_B2 = q30("0.99538200");
	localparam coef_t HP_A1 = q30("1.99074267");
	localparam coef_t HP_A2 = q30("-0.99078531");

	// floor(c*v / 2^30) from the two registered partial products
	function automatic logic signed [51:0] q30_fin(input logic signed [59:0] ph,
			input logic signed [52:0] pl);
		logic signed [60:0] t;
		logic signed [60:0] sh;
		t = 61'(ph) + 61'(pl >>> 20);
		sh = t >>> 10;
		return sh[51:0];
	endfunction

	function automatic logic signed [ST_W-1:0] sat_st(input logic signed [53:0] v);
		logic signed [ST_W-1:0] r;
		if (v > ST_MAX_W) r = ST_MAX_W[ST_W-1:0];
		else if (v < ST_MIN_W) r = ST_MIN_W[ST_W-1:0];
		else r = v[ST_W-1:0];
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/oufr_ctrl.sv =====
// ----------------------------------------------------------------------------
// oufr_ctrl
// Sequencer: band sweep, high-pass steps, mix and output handshake.
// ----------------------------------------------------------------------------
`default_nettype none
module oufr_ctrl #(
	parameter int BANDS = oufr_pkg::BANDS_DEF,
	parameter int IW    = 6
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output oufr_pkg::cmd_t       cmd,
	output logic [IW-1:0]        band_idx
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_BAND = 4'd1;
	localparam logic [3:0] S_DRN1 = 4'd2;
	localparam logic [3:0] S_DRN2 = 4'd3;
	localparam logic [3:0] S_HP1  = 4'd4;
	localparam logic [3:0] S_HP2  = 4'd5;
	localparam logic [3:0] S_HP3  = 4'd6;
	localparam logic [3:0] S_HP4  = 4'd7;
	localparam logic [3:0] S_MIX1 = 4'd8;
	localparam logic [3:0] S_MIX2 = 4'd9;

	localparam logic [IW-1:0] LAST = IW'(BANDS - 1);

	logic [3:0]    state_q, state_d;
	logic [IW-1:0] cnt_q;
	logic          oval_q;
	logic          out_free;

	assign out_free  = !oval_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = oval_q;
	assign band_idx  = cnt_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d = S_BAND;
				end
			end
			S_BAND: begin
				cmd.band_go = 1'b1;
				if (cnt_q == LAST) state_d = S_DRN1;
			end
			S_DRN1: state_d = S_DRN2;
			S_DRN2: state_d = S_HP1;
			S_HP1: begin
				cmd.hp_mul_s = 1'b1;
				state_d = S_HP2;
			end
			S_HP2: begin
				cmd.hp_h = 1'b1;
				state_d = S_HP3;
			end
			S_HP3: begin
				cmd.hp_mul_h = 1'b1;
				state_d = S_HP4;
			end
			S_HP4: begin
				cmd.hp_st = 1'b1;
				state_d = S_MIX1;
			end
			S_MIX1: begin
				cmd.mix_mul = 1'b1;
				state_d = S_MIX2;
			end
			S_MIX2: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			oval_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.start) cnt_q <= '0;
			else if (cmd.band_go) cnt_q <= cnt_q + 1'b1;
			if (cmd.out_load) oval_q <= 1'b1;
			else if (out_ready) oval_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!oval_q || out_ready))
		else $error("output overwritten while held");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_BAND |-> cnt_q <= LAST)
		else $error("band index past last band");
	a_start_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> (state_q == S_BAND && cnt_q == '0))
		else $error("sweep did not start at band zero");
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		(oval_q && !out_ready) |=> oval_q)
		else $error("result dropped");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/oufr_dp.sv =====
// ----------------------------------------------------------------------------
// oufr_dp
// Datapath: band state memory, three Q2.30 multiplier lanes, high-pass,
// gain registers and output mixer.
// ----------------------------------------------------------------------------
`default_nettype none
module oufr_dp #(
	parameter int BANDS       = oufr_pkg::BANDS_DEF,
	parameter int SAMPLE_BITS = oufr_pkg::SAMPLE_BITS_DEF,
	parameter int IW          = 6
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire oufr_pkg::cmd_t                cmd,
	input  wire logic [IW-1:0]                 band_idx,
	input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
	input  wire logic                          wr_en,
	input  wire logic [oufr_pkg::REG_IDX_W-1:0] wr_index,
	input  wire logic [oufr_pkg::GW-1:0]       wr_data,
	output logic signed [SAMPLE_BITS-1:0]      sample_out
);

	localparam int SW = SAMPLE_BITS;
	localparam int MW = 50;
	localparam logic signed [MW-1:0] SMAX = (MW'(1) <<< (SW - 1)) - MW'(1);
	localparam logic signed [MW-1:0] SMIN = -SMAX - MW'(1);

	// config
	logic [oufr_pkg::GW-1:0] clean_q, gain_a_q, gain_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clean_q  <= oufr_pkg::GAIN_RESET;
			gain_a_q <= oufr_pkg::GAIN_RESET;
			gain_b_q <= oufr_pkg::GAIN_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				oufr_pkg::REG_CLEAN: clean_q  <= wr_data;
				oufr_pkg::REG_OCT_A: gain_a_q <= wr_data;
				oufr_pkg::REG_OCT_B: gain_b_q <= wr_data;
				default: ;
			endcase
		end
	end

	// input delays
	logic signed [SW-1:0] x_q, xd1_q, xd2_q;
	logic signed [SW:0]   d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xd1_q <= '0;
			xd2_q <= '0;
		end else if (cmd.start) begin
			xd1_q <= sample_in;
			xd2_q <= xd1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q <= sample_in;
			d_q <= (SW+1)'(sample_in) - (SW+1)'(xd2_q);
		end
	end

	// band state memory {y2, y1}, valid bits stand for reset-to-zero
	logic [2*oufr_pkg::ST_W-1:0] st_mem [BANDS];
	logic [BANDS-1:0]            vld_q;
	logic [2*oufr_pkg::ST_W-1:0] rd_s1;
	logic                        rv_s1;
	logic                        go_s1, go_s2;
	logic [IW-1:0]               idx_s1, idx_s2;
	logic signed [oufr_pkg::ST_W-1:0] y1_s2;
	logic signed [oufr_pkg::ST_W-1:0] y_new;

	always_ff @(posedge clk) begin
		if (cmd.band_go) begin
			rd_s1 <= st_mem[band_idx];
		end
		if (go_s2) begin
			st_mem[idx_s2] <= {y1_s2, y_new};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			go_s1 <= 1'b0;
			go_s2 <= 1'b0;
		end else begin
			go_s1 <= cmd.band_go;
			go_s2 <= go_s1;
			if (go_s2) vld_q[idx_s2] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.band_go) begin
			rv_s1  <= vld_q[band_idx];
			idx_s1 <= band_idx;
		end
		if (go_s1) idx_s2 <= idx_s1;
	end

	// multiplier lanes
	logic signed [oufr_pkg::ST_W-1:0] y1_rd, y2_rd;
	logic [5:0]                      rom_idx;
	oufr_pkg::coef_t                 lc [3];
	logic signed [oufr_pkg::VW-1:0]  lv [3];
	logic signed [59:0]              ph_s2 [3];
	logic signed [52:0]              pl_s2 [3];
	logic signed [51:0]              r [3];
	logic signed [oufr_pkg::ST_W-1:0] h_q, hs1_q, hs2_q;
	logic signed [51:0]              t1_q, t2_q;
	logic [38:0]                     acc_q;

	assign y1_rd   = rv_s1 ? $signed(rd_s1[oufr_pkg::ST_W-1:0]) : '0;
	assign y2_rd   = rv_s1 ? $signed(rd_s1[2*oufr_pkg::ST_W-1:oufr_pkg::ST_W]) : '0;
	assign rom_idx = 6'(idx_s1);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			lc[k] = '0;
			lv[k] = '0;
		end
		if (go_s1) begin
			lc[0] = oufr_pkg::ROM_B0[rom_idx];
			lv[0] = oufr_pkg::VW'(d_q) <<< 12;
			lc[1] = oufr_pkg::ROM_A1[rom_idx];
			lv[1] = oufr_pkg::VW'(y1_rd);
			lc[2] = oufr_pkg::ROM_A2[rom_idx];
			lv[2] = oufr_pkg::VW'(y2_rd);
		end else if (cmd.hp_mul_s) begin
			lc[0] = oufr_pkg::HP_B0;
			lv[0] = oufr_pkg::VW'({1'b0, acc_q});
			lc[1] = oufr_pkg::HP_B1;
			lv[1] = oufr_pkg::VW'({1'b0, acc_q});
			lc[2] = oufr_pkg::HP_B2;
			lv[2] = oufr_pkg::VW'({1'b0, acc_q});
		end else if (cmd.hp_mul_h) begin
			lc[1] = oufr_pkg::HP_A1;
			lv[1] = oufr_pkg::VW'(h_q);
			lc[2] = oufr_pkg::HP_A2;
			lv[2] = oufr_pkg::VW'(h_q);
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1) y1_s2 <= y1_rd;
		for (int k = 0; k < 3; k++) begin
			ph_s2[k] <= lc[k] * $signed(lv[k][oufr_pkg::VW-1:20]);
			pl_s2[k] <= lc[k] * $signed({1'b0, lv[k][19:0]});
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			r[k] = oufr_pkg::q30_fin(ph_s2[k], pl_s2[k]);
		end
	end

	// band output and rectified sum
	logic [oufr_pkg::ST_W:0] abs_y;
	logic [40:0]             acc_nx;

	assign y_new  = oufr_pkg::sat_st(54'(r[0]) - 54'(r[1]) - 54'(r[2]));
	assign abs_y  = y_new[oufr_pkg::ST_W-1] ? -(oufr_pkg::ST_W+1)'(y_new)
	                                        : (oufr_pkg::ST_W+1)'(y_new);
	assign acc_nx = {2'b0, acc_q} + abs_y;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q <= '0;
		end else if (go_s2) begin
			acc_q <= (acc_nx[40:39] != 2'b0) ? '1 : acc_nx[38:0];
		end
	end

	// high-pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hs1_q <= '0;
			hs2_q <= '0;
		end else if (cmd.hp_st) begin
			hs1_q <= oufr_pkg::sat_st(54'(t1_q) + 54'(r[1]) + 54'(hs2_q));
			hs2_q <= oufr_pkg::sat_st(54'(t2_q) + 54'(r[2]));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.hp_h) begin
			h_q  <= oufr_pkg::sat_st(54'(r[0]) + 54'(hs1_q));
			t1_q <= r[1];
			t2_q <= r[2];
		end
	end

	// mix
	logic signed [oufr_pkg::ST_W:0] h_adj;
	logic signed [28:0]             o_int;
	logic [16:0]                    g_sum;
	logic signed [46:0]             po_s2;
	logic signed [SW+16:0]          px_s2;
	logic signed [MW-1:0]           m_sum, m_adj, m_q;

	assign h_adj = (oufr_pkg::ST_W+1)'(h_q) + (h_q[oufr_pkg::ST_W-1] ? 41'sd4095 : 41'sd0);
	assign o_int = 29'(h_adj >>> 12);
	assign g_sum = {1'b0, gain_a_q} + {1'b0, gain_b_q};

	always_ff @(posedge clk) begin
		if (cmd.mix_mul) begin
			po_s2 <= o_int * $signed({1'b0, g_sum});
			px_s2 <= x_q * $signed({1'b0, clean_q});
		end
	end

	assign m_sum = MW'(po_s2) + MW'(px_s2);
	assign m_adj = m_sum + (m_sum[MW-1] ? MW'(4095) : MW'(0));
	assign m_q   = m_adj >>> 12;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (m_q > SMAX) sample_out <= SMAX[SW-1:0];
			else if (m_q < SMIN) sample_out <= SMIN[SW-1:0];
			else sample_out <= m_q[SW-1:0];
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/octave_up_filterbank_rectifier.sv =====
// ----------------------------------------------------------------------------
// octave_up_filterbank_rectifier
// Band-pass bank, full-wave rectifier, DC-blocking high-pass and dry/wet
// mixer. Doubles the pitch of the input audio.
// ----------------------------------------------------------------------------
//  channel | signals                          | direction
//  input   | in_valid, in_ready, sample_in    | item in
//  output  | out_valid, out_ready, sample_out | item out
//  config  | wr_en, wr_index, wr_data         | register write, no wait
//
//  An item goes from accept to result as a sweep of the BANDS band sections,
//  one band section per cycle through the shared multiplier lanes and the
//  band state memory port, plus the drain states DRN1 and DRN2, four high-pass
//  steps and two mix steps. Next item is taken once the sequencer is back in
//  idle, so a new item is not taken before the last one reaches its final load.
//  Reset clears states, valid bits and gains (4096) at once; no sweep.
//  A held output stalls only the final load; the next input is accepted
//  while a result still waits.
// ----------------------------------------------------------------------------
`default_nettype none
module octave_up_filterbank_rectifier #(
	parameter int BANDS       = oufr_pkg::BANDS_DEF,
	parameter int SAMPLE_BITS = oufr_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0]  sample_in,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic signed [SAMPLE_BITS-1:0]       sample_out,
	input  wire logic                           wr_en,
	input  wire logic [oufr_pkg::REG_IDX_W-1:0] wr_index,
	input  wire logic [oufr_pkg::GW-1:0]        wr_data
);

	// band index width; one bit minimum for a single band
	localparam int IW = (BANDS > 1) ? $clog2(BANDS) : 1;

	oufr_pkg::cmd_t cmd;
	logic [IW-1:0]  band_idx;

	// sequencer
	oufr_ctrl #(
		.BANDS (BANDS),
		.IW    (IW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.band_idx  (band_idx)
	);

	// arithmetic, states and output register
	oufr_dp #(
		.BANDS       (BANDS),
		.SAMPLE_BITS (SAMPLE_BITS),
		.IW          (IW)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.band_idx   (band_idx),
		.sample_in  (sample_in),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.sample_out (sample_out)
	);

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the octave-up filter bank. A bit-exact model of the
// band bank, rectifier, DC high-pass and mixer predicts each output item.
// Items are pushed through random idle gaps and output back-pressure, and
// the gains are swept between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

	localparam int NB        = oufr_pkg::BANDS_DEF;
	localparam int SB        = oufr_pkg::SAMPLE_BITS_DEF;
	localparam int WDOG_MAX  = 4000;  // cycles with no item moving on either side and no register write
	localparam int DRAIN     = 100;   // settle time after the last item is back
	localparam logic [oufr_pkg::REG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [SB-1:0] sample_in = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [SB-1:0] sample_out;
	logic wr_en = 1'b0;
	logic [oufr_pkg::REG_IDX_W-1:0] wr_index = oufr_pkg::REG_CLEAN;
	logic [oufr_pkg::GW-1:0] wr_data = '0;

	always #6 clk = ~clk;

	octave_up_filterbank_rectifier dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .sample_in(sample_in),
		.out_valid(out_valid), .out_ready(out_ready), .sample_out(sample_out),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	// ---------------- bit-exact filter bank model ----------------
	typedef logic signed [127:0] wide_t;
	typedef logic signed [oufr_pkg::ST_W-1:0] st_t;

	logic [oufr_pkg::GW-1:0] clean_w, oct_a_w, oct_b_w;
	logic signed [SB-1:0] x_d1, x_d2;
	st_t band_y1 [NB];
	st_t band_y2 [NB];
	st_t hp_s1, hp_s2;

	logic signed [SB-1:0] pending_samples [$];
	logic signed [SB-1:0] expected_samples [$];

	int n_sent, n_checked, n_fail, n_sat;

	// floor(c * v / 2^30)
	function automatic wide_t q30_mul(input oufr_pkg::coef_t c, input wide_t v);
		wide_t cw;
		cw = c;
		return (cw * v) >>> 30;
	endfunction

	function automatic st_t clamp40(input wide_t v);
		wide_t hi, lo;
		hi = (wide_t'(1) <<< (oufr_pkg::ST_W - 1)) - 1;
		lo = -(wide_t'(1) <<< (oufr_pkg::ST_W - 1));
		if (v > hi) return hi[oufr_pkg::ST_W-1:0];
		if (v < lo) return lo[oufr_pkg::ST_W-1:0];
		return v[oufr_pkg::ST_W-1:0];
	endfunction

	task automatic model_reset();
		clean_w = oufr_pkg::GAIN_RESET;
		oct_a_w = oufr_pkg::GAIN_RESET;
		oct_b_w = oufr_pkg::GAIN_RESET;
		x_d1 = '0;
		x_d2 = '0;
		hp_s1 = '0;
		hp_s2 = '0;
		for (int i = 0; i < NB; i++) begin
			band_y1[i] = '0;
			band_y2[i] = '0;
		end
	endtask

	// one input item -> one expected output item
	task automatic predict_octave_mix(input logic signed [SB-1:0] x);
		wide_t d, y, sum, hsum, s1n;
		st_t ys, h;
		oufr_pkg::coef_t b0, a1, a2;
		longint o, mix, smax;
		smax = (longint'(1) <<< (SB - 1)) - 1;
		d = wide_t'(x) - wide_t'(x_d2);
		sum = '0;
		hsum = (wide_t'(1) <<< (oufr_pkg::ST_W - 1)) - 1;
		for (int i = 0; i < NB; i++) begin
			b0 = (i < oufr_pkg::TAB_LEN) ? oufr_pkg::ROM_B0[i] : '0;
			a1 = (i < oufr_pkg::TAB_LEN) ? oufr_pkg::ROM_A1[i] : '0;
			a2 = (i < oufr_pkg::TAB_LEN) ? oufr_pkg::ROM_A2[i] : '0;
			y = q30_mul(b0, d * 4096) - q30_mul(a1, wide_t'(band_y1[i]))
				- q30_mul(a2, wide_t'(band_y2[i]));
			ys = clamp40(y);
			band_y2[i] = band_y1[i];
			band_y1[i] = ys;
			sum = sum + ((ys < 0) ? -wide_t'(ys) : wide_t'(ys));
			if (sum > hsum) sum = hsum;
		end
		x_d2 = x_d1;
		x_d1 = x;
		// DC blocker, transposed direct form II
		h = clamp40(q30_mul(oufr_pkg::HP_B0, sum) + wide_t'(hp_s1));
		s1n = q30_mul(oufr_pkg::HP_B1, sum) + q30_mul(oufr_pkg::HP_A1, wide_t'(h))
			+ wide_t'(hp_s2);
		hp_s2 = clamp40(q30_mul(oufr_pkg::HP_B2, sum) + q30_mul(oufr_pkg::HP_A2, wide_t'(h)));
		hp_s1 = clamp40(s1n);
		o = longint'(h) / 4096;  // toward zero
		mix = (o * (longint'(oct_a_w) + longint'(oct_b_w)) + longint'(x) * longint'(clean_w))
			/ 4096;
		if (mix > smax) begin mix = smax; n_sat++; end
		if (mix < -smax - 1) begin mix = -smax - 1; n_sat++; end
		expected_samples.push_back(mix[SB-1:0]);
	endtask

	// ---------------- input driver ----------------
	int  in_gap;
	bit  in_burst;  // no idle gaps while set

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap <= 0;
		end else begin
			if (in_valid && in_ready) begin
				predict_octave_mix(sample_in);
				n_sent++;
			end
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_samples.size() != 0) begin
					in_valid <= 1'b1;
					sample_in <= pending_samples.pop_front();
					in_gap <= in_burst ? 0 : $urandom_range(0, 5);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------- output monitor ----------------
	int  out_stall;
	bit  out_burst;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_stall <= 0;
		end else if (out_valid && out_ready) begin
			if (expected_samples.size() == 0) begin
				n_fail++;
				if (n_fail <= 10)
					$display("%0t: unexpected output item %0d", $realtime, sample_out);
			end else begin
				if (sample_out !== expected_samples[0]) begin
					n_fail++;
					if (n_fail <= 10)
						$display("%0t: sample_out mismatch, expected %0d got %0d",
							$realtime, expected_samples[0], sample_out);
				end
				void'(expected_samples.pop_front());
				n_checked++;
			end
			out_stall <= out_burst ? 0 : $urandom_range(0, 5);
			out_ready <= out_burst ? 1'b1 : 1'b0;
		end else if (out_stall > 0) begin
			out_stall <= out_stall - 1;
			out_ready <= (out_stall == 1);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// ---------------- watchdog ----------------
	int idle_cycles;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || wr_en)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX) begin
			$display("watchdog: no progress for %0d cycles", WDOG_MAX);
			$display("tb_top failed");
			$finish;
		end
	end

	// ---------------- sequencing ----------------
	// back-to-back register writes, one per cycle; model follows at once
	task automatic write_gains(input logic [oufr_pkg::GW-1:0] cg,
			input logic [oufr_pkg::GW-1:0] ga, input logic [oufr_pkg::GW-1:0] gb);
		@(posedge clk);
		wr_en <= 1'b1; wr_index <= oufr_pkg::REG_CLEAN; wr_data <= cg;
		@(posedge clk);
		wr_index <= oufr_pkg::REG_OCT_A; wr_data <= ga;
		@(posedge clk);
		wr_index <= oufr_pkg::REG_OCT_B; wr_data <= gb;
		@(posedge clk);
		// unmapped index, must be dropped
		wr_index <= REG_UNMAPPED; wr_data <= oufr_pkg::GW'($urandom);
		@(posedge clk);
		wr_en <= 1'b0;
		clean_w = cg;
		oct_a_w = ga;
		oct_b_w = gb;
	endtask

	// hold off until every item is back, then let the sequencer settle
	task automatic drain_all();
		while (pending_samples.size() != 0 || in_valid || expected_samples.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	// random content: mostly periodic tones that ring the bands, some noise and full-scale extremes
	task automatic queue_random(input int n);
		int k, per, amp, ph;
		k = 0;
		while (k < n) begin
			case ($urandom_range(0, 5))
				0: begin
					pending_samples.push_back(SB'($urandom));
					k++;
				end
				1: begin
					pending_samples.push_back(($urandom_range(0, 1) != 0) ?
						{1'b0, {(SB-1){1'b1}}} : {1'b1, {(SB-1){1'b0}}});
					k++;
				end
				default: begin
					per = $urandom_range(2, 40);
					amp = $urandom_range(1, (1 << (SB - 1)) - 1);
					ph = $urandom_range(0, per - 1);
					for (int j = 0; j < $urandom_range(8, 40) && k < n; j++) begin
						// square or sawtooth wave
						if ($urandom_range(0, 1) == 0 || per < 4)
							pending_samples.push_back((((j + ph) % per) < per / 2) ?
								SB'(amp) : SB'(-amp));
						else
							pending_samples.push_back(SB'(longint'(amp) *
								(2 * ((j + ph) % per) - per) / per));
						k++;
					end
				end
			endcase
		end
	endtask

	initial begin
		model_reset();
		n_sent = 0; n_checked = 0; n_fail = 0; n_sat = 0;
		idle_cycles = 0;
		in_burst = 1'b0;
		out_burst = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, sign flips, steps, full-scale alternation
		pending_samples.push_back('0);
		pending_samples.push_back({1'b0, {(SB-1){1'b1}}});
		pending_samples.push_back({1'b1, {(SB-1){1'b0}}});
		pending_samples.push_back('1);
		pending_samples.push_back(SB'(1));
		for (int i = 0; i < 8; i++)
			pending_samples.push_back(i[0] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}});
		for (int i = 0; i < 6; i++) pending_samples.push_back({1'b0, {(SB-1){1'b1}}});
		pending_samples.push_back(SB'(24'h555555));
		pending_samples.push_back(SB'(24'haaaaaa));
		pending_samples.push_back('0);
		drain_all();

		// maximum gains, saturating mix
		write_gains('1, '1, '1);
		in_burst = 1'b1;
		out_burst = 1'b1;
		queue_random(60);
		drain_all();
		in_burst = 1'b0;
		queue_random(60);
		drain_all();

		// all gains zero
		out_burst = 1'b0;
		write_gains('0, '0, '0);
		queue_random(60);
		drain_all();

		// dry only, then wet only, then random settings
		write_gains(oufr_pkg::GAIN_RESET, '0, '0);
		queue_random(60);
		drain_all();
		write_gains('0, '1, '0);
		queue_random(60);
		drain_all();
		for (int p = 0; p < 6; p++) begin
			write_gains(oufr_pkg::GW'($urandom), oufr_pkg::GW'($urandom),
				oufr_pkg::GW'($urandom));
			in_burst = (p == 2);
			out_burst = (p == 3);
			queue_random(65);
			drain_all();
		end

		$display("checked %0d of %0d items over 11 gain settings", n_checked, n_sent);
		$display("saturated outputs predicted: %0d, mismatches: %0d", n_sat, n_fail);
		if (n_fail == 0 && expected_samples.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
`default_nettype wire
